FILE: design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions of the positional list engine
// Field widths, operation codes and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned OP_W             = 2;
  localparam int unsigned POS_W            = 7;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned COUNT_W          = 7;
  localparam int unsigned DEFAULT_CAPACITY = 64;

  // Word returned by a read that fails.
  localparam logic signed [DATA_W-1:0] READ_FAIL_WORD = -32'sd1;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } ple_op_e;

  // Broadcast to every cell; apply is set only for a successful transfer.
  typedef struct packed {
    logic    apply;
    ple_op_e op;
  } ple_cell_ctrl_t;

endpackage

FILE: design/ple_if.sv
// ----------------------------------------------------------------------------
// ple_if: request and response channels of the positional list engine
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ple_req_if import ple_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] read_data;
  logic [COUNT_W-1:0]       count;
  logic                     is_empty;

  modport source (output valid, ok, read_data, count, is_empty, input ready);
  modport sink   (input valid, ok, read_data, count, is_empty, output ready);
endinterface

FILE: design/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell: one list entry
// Holds one word and, from the broadcast position, decides whether to keep
// it, load the new word, or take the word of its lower or upper neighbour.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned PW    = 8
) (
  input  logic                     clk_i,
  input  ple_cell_ctrl_t           ctrl_i,
  input  logic [PW-1:0]            pos0_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic signed [DATA_W-1:0] lower_i,
  input  logic signed [DATA_W-1:0] upper_i,
  output logic signed [DATA_W-1:0] word_o,
  output logic [DATA_W-1:0]        rd_o
);

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  logic                     hit;
  logic                     above;
  logic signed [DATA_W-1:0] word_q;
  logic signed [DATA_W-1:0] word_d;

  assign hit   = (pos0_i == MY_IDX);
  assign above = (pos0_i < MY_IDX);

  always_comb begin
    word_d = word_q;
    if (ctrl_i.apply) begin
      case (ctrl_i.op)
        OP_WRITE: begin
          if (hit) word_d = value_i;
        end
        OP_INSERT: begin
          if (hit) begin
            word_d = value_i;
          end else if (above) begin
            word_d = lower_i;
          end
        end
        OP_REMOVE: begin
          if (hit || above) word_d = upper_i;
        end
        default: word_d = word_q;
      endcase
    end
  end

  // Entry storage has no reset; entries at or past the count are never read.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  // Masked word so that the read port is a plain OR over all cells.
  assign rd_o   = hit ? word_q : '0;

endmodule

FILE: design/positional_list_engine.sv
// The response of a request is registered and presented in the cycle after its transfer.
// One request per cycle while responses are taken; every cell of the chain updates
// in the same cycle, so insert and remove cost no more than read and overwrite.
// A response that is not taken holds the request channel until it is.
// Reset clears the entry count and the response valid; entry words are not
// cleared and are never returned before they have been written.
// ----------------------------------------------------------------------------
// positional_list_engine: bounded list addressed by 1-based position
// Read, overwrite, insert and remove on a chain of cells that shift in
// parallel, with a registered response stage.
// ----------------------------------------------------------------------------
module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ple_req_if.sink   req,
  ple_rsp_if.source rsp
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [CNT_W-1:0]         cnt_q;
  logic [CNT_W-1:0]         cnt_d;
  logic [CMP_W-1:0]         cnt_ext;
  logic [CMP_W-1:0]         cnt_next_ext;
  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         pos0;
  logic                     pos_in_list;
  logic                     pos_for_ins;
  logic                     full;
  logic                     accept;
  logic                     op_ok;
  ple_op_e                  op;
  ple_cell_ctrl_t           ctrl;
  logic [DATA_W-1:0]        rd_word;
  logic signed [DATA_W-1:0] rsp_data;

  logic                     rsp_vld_q;
  logic                     ok_q;
  logic signed [DATA_W-1:0] data_q;
  logic [COUNT_W-1:0]       count_q;
  logic                     empty_q;

  logic signed [DATA_W-1:0] words [CAPACITY];
  logic [DATA_W-1:0]        rd_bus [CAPACITY];

  assign op      = ple_op_e'(req.operation);
  assign accept  = req.valid && req.ready;
  assign req.ready = !rsp_vld_q || rsp.ready;

  assign cnt_ext     = CMP_W'(cnt_q);
  assign pos_ext     = CMP_W'(req.position);
  assign pos0        = pos_ext - CMP_W'(1);
  assign full        = (cnt_ext == CMP_W'(CAPACITY));
  assign pos_in_list = (req.position != '0) && (pos_ext <= cnt_ext);
  assign pos_for_ins = (req.position != '0) && (pos_ext <= cnt_ext + CMP_W'(1));

  always_comb begin
    case (op)
      OP_INSERT: op_ok = pos_for_ins && !full;
      default:   op_ok = pos_in_list;
    endcase
  end

  assign ctrl.apply = accept && op_ok;
  assign ctrl.op    = op;

  always_comb begin
    cnt_d = cnt_q;
    if (accept && op_ok) begin
      case (op)
        OP_INSERT: cnt_d = cnt_q + CNT_W'(1);
        OP_REMOVE: cnt_d = cnt_q - CNT_W'(1);
        default:   cnt_d = cnt_q;
      endcase
    end
  end

  assign cnt_next_ext = CMP_W'(cnt_d);

  // Chain of cells; each takes from its lower neighbour on insert and from
  // its upper neighbour on remove.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] lower;
    logic signed [DATA_W-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = req.value;
    end else begin : g_mid_lo
      assign lower = words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper = req.value;
    end else begin : g_mid_hi
      assign upper = words[i+1];
    end

    ple_cell #(
      .IDX (i),
      .PW  (CMP_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos0_i  (pos0),
      .value_i (req.value),
      .lower_i (lower),
      .upper_i (upper),
      .word_o  (words[i]),
      .rd_o    (rd_bus[i])
    );
  end

  // At most one cell matches the position, so the read port is an OR.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | rd_bus[i];
    end
  end

  always_comb begin
    rsp_data = '0;
    if (op == OP_READ) begin
      rsp_data = pos_in_list ? $signed(rd_word) : READ_FAIL_WORD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q    <= op_ok;
      data_q  <= rsp_data;
      count_q <= cnt_next_ext[COUNT_W-1:0];
      empty_q <= (cnt_d == '0);
    end
  end

  assign rsp.valid     = rsp_vld_q;
  assign rsp.ok        = ok_q;
  assign rsp.read_data = data_q;
  assign rsp.count     = count_q;
  assign rsp.is_empty  = empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_INSERT && op_ok) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("successful insert did not grow the list by one");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_REMOVE && op_ok) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("successful remove did not shrink the list by one");

  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (rsp_vld_q && count_q == $past(cnt_next_ext[COUNT_W-1:0])))
    else $error("transfer not followed by its response");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q |-> (empty_q == (count_q == '0)))
    else $error("empty flag disagrees with count");

endmodule
